@@ src/btoi_pkg.sv @@
package btoi_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int BASE_LEN_W  = 5;
    localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_LENGTH  = 2'd2;

    localparam logic [BASE_LEN_W-1:0] BASE_LEN_RESET = 5'd10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          table_valid;
        logic                          overflowed;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] symbols_low;
        logic [CFG_DATA_W-1:0] symbols_high;
        logic [BASE_LEN_W-1:0] base_length;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_NEG,
        OP_DIGIT
    } t_op_kind;

    // One classified byte as handed from the front end to the back end.
    typedef struct packed {
        t_op_kind              kind;
        logic [DIGIT_W-1:0]    digit;
        logic [BASE_LEN_W-1:0] radix;
        logic                  last;
        logic                  table_ok;
    } t_op;

endpackage

@@ src/btoi_front.sv @@
module btoi_front
    import btoi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output t_op      o_op
);

    t_phase r_phase;
    t_phase n_phase;

    logic [7:0] w_sym [MAX_SYMBOLS];
    logic       w_used [MAX_SYMBOLS];
    logic       w_tbl_ok;
    logic       w_is_digit;
    logic [DIGIT_W-1:0] w_digit;
    logic       w_ws;

    always_comb begin
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i < 8) begin
                w_sym[i] = i_cfg.symbols_low[8*(i%8) +: 8];
            end else begin
                w_sym[i] = i_cfg.symbols_high[8*(i%8) +: 8];
            end
            w_used[i] = BASE_LEN_W'(i) < i_cfg.base_length;
        end
    end

    // Table check: length in range, legal symbols, no repeats among used ones.
    always_comb begin
        w_tbl_ok = (i_cfg.base_length >= BASE_LEN_W'(2)) &&
                   (i_cfg.base_length <= BASE_LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (w_used[i] && ((w_sym[i] <= CH_SPACE) || (w_sym[i] == CH_PLUS) ||
                              (w_sym[i] == CH_MINUS) || (w_sym[i] == CH_DEL))) begin
                w_tbl_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                if (w_used[i] && w_used[j] && (w_sym[i] == w_sym[j])) begin
                    w_tbl_ok = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_is_digit = 1'b0;
        w_digit    = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (w_used[i] && (w_sym[i] == i_beat.text_byte)) begin
                w_is_digit = w_tbl_ok;
                w_digit    = DIGIT_W'(i);
            end
        end
    end

    assign w_ws = ((i_beat.text_byte >= CH_TAB) && (i_beat.text_byte <= CH_CR)) ||
                  (i_beat.text_byte == CH_SPACE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    // Phases fall through within one byte, same as the sequential parse.
    always_comb begin
        t_phase ph;
        ph           = r_phase;
        o_op.kind    = OP_NONE;
        o_op.digit   = w_digit;
        o_op.radix   = i_cfg.base_length;
        o_op.last    = i_beat.end_of_text;
        o_op.table_ok = w_tbl_ok;
        if (ph == PH_SPACE && !w_ws) begin
            ph = PH_SIGN;
        end
        if (ph == PH_SIGN) begin
            if (i_beat.text_byte == CH_MINUS) begin
                o_op.kind = OP_NEG;
            end else if (i_beat.text_byte != CH_PLUS) begin
                ph = PH_DIGIT;
            end
        end
        if (ph == PH_DIGIT) begin
            if (w_is_digit) begin
                o_op.kind = OP_DIGIT;
            end else begin
                ph = PH_DONE;
            end
        end
        n_phase = i_beat.end_of_text ? PH_SPACE : ph;
    end

endmodule

@@ src/btoi_queue.sv @@
module btoi_queue
    import btoi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

@@ src/btoi_back.sv @@
module btoi_back
    import btoi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int PROD_W = VALUE_WIDTH + BASE_LEN_W;
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_ovf;
    logic                   n_neg;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic                   n_ovf;

    logic      r_out_valid;
    t_out_beat r_out;

    logic              w_slot_free;
    logic [PROD_W-1:0] w_sum;
    t_out_beat         w_res;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    // A final beat waits until the output register can take its result.
    assign o_pop = !i_empty && (!i_op.last || w_slot_free);

    assign w_sum = PROD_W'(r_acc) * PROD_W'(i_op.radix) + PROD_W'(i_op.digit);

    always_comb begin
        logic                   neg;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   ovf;
        neg = r_neg;
        acc = r_acc;
        ovf = r_ovf;
        case (i_op.kind)
            OP_NEG: begin
                neg = !r_neg;
            end
            OP_DIGIT: begin
                acc = w_sum[VALUE_WIDTH-1:0];
                // magnitude above the largest positive value
                if (|w_sum[PROD_W-1:VALUE_WIDTH-1]) begin
                    ovf = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (!i_op.table_ok) begin
            w_res = '0;
        end else begin
            w_res.value       = neg ? -$signed(acc) : $signed(acc);
            w_res.table_valid = 1'b1;
            w_res.overflowed  = ovf || (neg && (acc == VAL_MIN));
        end

        if (i_op.last) begin
            n_neg = 1'b0;
            n_acc = '0;
            n_ovf = 1'b0;
        end else begin
            n_neg = neg;
            n_acc = acc;
            n_ovf = ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_neg <= n_neg;
                r_acc <= n_acc;
                r_ovf <= n_ovf;
            end
            if (w_slot_free) begin
                r_out_valid <= o_pop && i_op.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && o_pop && i_op.last) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_bad_table_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.table_valid) |-> (r_out.value == '0) && !r_out.overflowed)
        else $error("invalid table result not cleared");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.last) |=> (r_acc == '0) && !r_neg && !r_ovf)
        else $error("parse state not cleared after final beat");

    a_neg_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_op.kind == OP_NEG) && !i_op.last) |=> r_neg != $past(r_neg))
        else $error("sign did not flip on minus");

endmodule

@@ src/base_n_text_to_integer.sv @@
// Base-N text to integer. Text enters one byte per beat; the beat with
// end_of_text set yields one result: the signed value (wrapped to 32 bits),
// table_valid and overflowed. The symbol table and radix come from three
// write-only registers (0: symbols 0..7, 1: symbols 8..15, 2: base length)
// and must be written while no text is in flight. The block sustains one
// byte per cycle while the queue is not full: the front end matches the
// byte against all symbols in parallel and tracks the whitespace/sign/digit
// phase, and the back end does one 32x5 multiply-add per byte. A 4-entry
// queue sits between them, so the front keeps taking bytes while a finished
// result waits at the output. The final byte is queued, then popped and its
// result registered when nothing older waits and the output is not stalled.
module base_n_text_to_integer
    import btoi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    t_cfg r_cfg;
    t_op  w_front_op;
    t_op  w_queue_op;
    logic w_take;
    logic w_pop;
    logic w_empty;
    logic w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.symbols_low  <= '0;
            r_cfg.symbols_high <= '0;
            r_cfg.base_length  <= BASE_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SYMBOLS_LOW:  r_cfg.symbols_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_cfg.symbols_high <= i_cfg_data;
                CFG_BASE_LENGTH:  r_cfg.base_length  <= i_cfg_data[BASE_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = w_full;
    assign w_take     = i_in_valid && !w_full;

    btoi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_beat  (i_in_data),
        .i_take  (w_take),
        .o_op    (w_front_op)
    );

    btoi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_op    (w_queue_op),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    btoi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_queue_op),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb.sv @@
module tb;
    import btoi_pkg::*;

    localparam longint unsigned SIGNED_MAX = 64'h7FFF_FFFF;
    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_CYCLES = 8;

    // ways to spoil a random table
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_REPEAT = 1;
    localparam int FLAW_LOW    = 2;
    localparam int FLAW_PLUS   = 3;
    localparam int FLAW_MINUS  = 4;
    localparam int FLAW_DEL    = 5;
    localparam int FLAW_SHORT  = 6;
    localparam int FLAW_LONG   = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SYMBOLS_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;

    base_n_text_to_integer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the register file
    logic [63:0] sym_lo = '0;
    logic [63:0] sym_hi = '0;
    logic [4:0]  radix = BASE_LEN_RESET;

    // parser state
    t_phase      text_phase = PH_SPACE;
    bit          minus_odd = 1'b0;
    logic [31:0] magnitude = '0;
    bit          wrap_seen = 1'b0;

    t_in_beat  pending_beats[$];
    t_out_beat expected_results[$];
    int        queued_beats = 0;
    int        mismatches = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    bit        quiet_in = 1'b0;
    bit        quiet_out = 1'b0;
    int        idle_cycles = 0;

    function automatic logic [7:0] symbol_at(int i);
        if (i < 8)
            return sym_lo[8*i +: 8];
        return sym_hi[8*(i-8) +: 8];
    endfunction

    function automatic bit table_is_good();
        logic [7:0] s;
        if (radix < 2 || radix > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < radix; i++) begin
            s = symbol_at(i);
            if (s <= CH_SPACE || s == CH_PLUS || s == CH_MINUS || s == CH_DEL)
                return 1'b0;
            for (int j = i + 1; j < radix; j++)
                if (symbol_at(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int symbol_index(logic [7:0] b);
        if (!table_is_good())
            return -1;
        for (int i = 0; i < radix; i++)
            if (symbol_at(i) == b)
                return i;
        return -1;
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // advance the parser by one accepted beat; a final beat yields a result
    task automatic advance_parser(t_in_beat beat);
        int              d;
        longint unsigned lim;
        logic [63:0]     wide;
        logic [31:0]     v;
        t_out_beat       res;
        logic [7:0]      b;
        b = beat.text_byte;
        if (text_phase == PH_SPACE && !((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE))
            text_phase = PH_SIGN;
        if (text_phase == PH_SIGN) begin
            if (b == CH_MINUS)
                minus_odd = !minus_odd;
            else if (b != CH_PLUS)
                text_phase = PH_DIGIT;
        end
        if (text_phase == PH_DIGIT) begin
            d = symbol_index(b);
            if (d < 0) begin
                text_phase = PH_DONE;
            end else begin
                lim = (SIGNED_MAX - 64'(d)) / radix;
                if ({32'd0, magnitude} > lim)
                    wrap_seen = 1'b1;
                wide = {32'd0, magnitude} * radix + 64'(d);
                magnitude = wide[31:0];
            end
        end
        if (beat.end_of_text) begin
            res = '0;
            if (table_is_good()) begin
                res.table_valid = 1'b1;
                res.overflowed = wrap_seen;
                v = magnitude;
                if (minus_odd) begin
                    if (v == 32'h8000_0000)
                        res.overflowed = 1'b1;
                    v = -v;
                end
                res.value = v;
            end
            expected_results.push_back(res);
            text_phase = PH_SPACE;
            minus_odd = 1'b0;
            magnitude = '0;
            wrap_seen = 1'b0;
        end
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall)
                advance_parser(in_beat);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        quiet_in = !quiet_in;
                    gap_left = draw_wait(quiet_in);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_out_beat want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result beat: value %0d valid %0b ovf %0b",
                                 out_beat.value, out_beat.table_valid, out_beat.overflowed);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_beat.value !== want.value
                            || out_beat.table_valid !== want.table_valid
                            || out_beat.overflowed !== want.overflowed) begin
                        if (mismatches < 10)
                            $display({"result mismatch: exp value %0d valid %0b ovf %0b,",
                                      " got value %0d valid %0b ovf %0b"},
                                     want.value, want.table_valid, want.overflowed,
                                     out_beat.value, out_beat.table_valid,
                                     out_beat.overflowed);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    quiet_out = !quiet_out;
                stall_left = draw_wait(quiet_out);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // watchdog on cycles where neither side moves a beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_beat(logic [7:0] b, bit last);
        t_in_beat beat;
        beat.text_byte = b;
        beat.end_of_text = last;
        pending_beats.push_back(beat);
        queued_beats++;
    endtask

    task automatic queue_string(string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], i == s.len() - 1);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        if (addr == CFG_SYMBOLS_LOW)
            sym_lo = data;
        else if (addr == CFG_SYMBOLS_HIGH)
            sym_hi = data;
        else if (addr == CFG_BASE_LENGTH)
            radix = data[4:0];
    endtask

    task automatic load_table(logic [63:0] lo, logic [63:0] hi, logic [4:0] n);
        write_reg(CFG_SYMBOLS_LOW, lo);
        write_reg(CFG_SYMBOLS_HIGH, hi);
        write_reg(CFG_BASE_LENGTH, {59'd0, n});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [127:0] pack_symbols(string s);
        logic [127:0] t;
        t = '0;
        for (int i = 0; i < s.len(); i++)
            t[8*i +: 8] = s[i];
        return t;
    endfunction

    // n symbols; the flaw either keeps the table legal, breaks one symbol,
    // or puts the radix out of range
    task automatic load_random_table(int n, int flaw);
        logic [7:0]   syms[16];
        logic [127:0] t;
        bit           ok;
        int           pos;
        logic [4:0]   len;
        for (int i = 0; i < 16; i++)
            syms[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < n; i++) begin
            do begin
                syms[i] = 8'($urandom_range(33, 255));
                ok = syms[i] != CH_PLUS && syms[i] != CH_MINUS && syms[i] != CH_DEL;
                for (int j = 0; j < i; j++)
                    if (syms[j] == syms[i])
                        ok = 1'b0;
            end while (!ok);
        end
        pos = $urandom_range(1, n - 1);
        case (flaw)
            FLAW_REPEAT: syms[pos] = syms[$urandom_range(0, pos - 1)];
            FLAW_LOW:    syms[pos] = 8'($urandom_range(0, CH_SPACE));
            FLAW_PLUS:   syms[pos] = CH_PLUS;
            FLAW_MINUS:  syms[pos] = CH_MINUS;
            FLAW_DEL:    syms[pos] = CH_DEL;
            default: ;
        endcase
        len = (flaw == FLAW_SHORT) ? 5'd1 : (flaw == FLAW_LONG) ? 5'd17 : 5'(n);
        for (int i = 0; i < 16; i++)
            t[8*i +: 8] = syms[i];
        load_table(t[63:0], t[127:64], len);
    endtask

    // one text: mostly whitespace, signs, digits and a tail; sometimes noise
    task automatic queue_text();
        logic [7:0]      text_q[$];
        int              n;
        int              k;
        int              nd;
        longint unsigned reach;
        logic [7:0]      w;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6))
                text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) begin
                    w = 8'($urandom_range(8, 13));
                    text_q.push_back((w == 8) ? CH_SPACE : w);
                end
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3))
                    text_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            n = (radix > 16) ? 16 : radix;
            k = 6;
            if (n >= 2) begin
                k = 0;
                reach = 1;
                while (reach < 64'h8000_0000) begin
                    reach = reach * n;
                    k++;
                end
            end
            nd = ($urandom_range(0, 3) == 0) ? $urandom_range(k - 1, k + 3)
                                              : $urandom_range(0, k);
            repeat (nd) begin
                if (n == 0)
                    text_q.push_back(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 3) == 0)
                    text_q.push_back(symbol_at(n - 1));
                else
                    text_q.push_back(symbol_at($urandom_range(0, n - 1)));
            end
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3))
                    text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (text_q.size() == 0)
            text_q.push_back(8'($urandom_range(0, 255)));
        foreach (text_q[i])
            push_beat(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic fill_texts(int budget);
        int target;
        target = queued_beats + budget;
        while (queued_beats < target)
            queue_text();
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [127:0] t;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // table after reset is all zero bytes: every text gives zero
        fill_texts(60);
        wait_idle();

        t = pack_symbols("0123456789");
        load_table(t[63:0], t[127:64], 5'd10);
        push_beat(CH_TAB, 1'b0);
        push_beat(CH_CR, 1'b0);
        push_beat(CH_SPACE, 1'b0);
        queue_string("+-5");
        queue_string("-2147483648");
        push_beat(8'h00, 1'b1);
        queue_string("3 4");
        queue_string("-");
        fill_texts(200);
        wait_idle();

        t = pack_symbols("0123456789ABCDEF");
        load_table(t[63:0], t[127:64], 5'd16);
        fill_texts(170);
        wait_idle();

        t = pack_symbols("01");
        load_table(t[63:0], t[127:64], 5'd2);
        fill_texts(170);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            case (p % 5)
                0: load_random_table($urandom_range(2, 16), FLAW_NONE);
                1: load_random_table(16, FLAW_NONE);
                2: load_random_table(2, FLAW_NONE);
                3: load_random_table($urandom_range(2, 16),
                                     $urandom_range(FLAW_REPEAT, FLAW_LONG));
                default: begin
                    if (p == 4)
                        load_table('0, '0, 5'd0);
                    else
                        load_table('1, '1, 5'd31);
                end
            endcase
            fill_texts(70);
            wait_idle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ files.f @@
src/btoi_pkg.sv
src/btoi_front.sv
src/btoi_queue.sv
src/btoi_back.sv
src/base_n_text_to_integer.sv
verif/tb.sv
